>>> rtl/jsu_pkg.sv
// Package with the types, character codes and helper functions of the JSON string unescaper.
package jsu_pkg;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_BODY    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEX     = 3'd3,
        PH_LOW_BSL = 3'd4,
        PH_LOW_U   = 3'd5,
        PH_LOW_HEX = 3'd6
    } t_phase;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes.
    localparam logic [3:0] ERR_QUOTE_EXPECTED = 4'd0;
    localparam logic [3:0] ERR_CONTROL_CHAR   = 4'd1;
    localparam logic [3:0] ERR_BAD_ESC_END    = 4'd2;
    localparam logic [3:0] ERR_INVALID_ESC    = 4'd3;
    localparam logic [3:0] ERR_INCOMPLETE_HEX = 4'd4;
    localparam logic [3:0] ERR_BAD_HEX        = 4'd5;
    localparam logic [3:0] ERR_MISSING_LOW    = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW        = 4'd7;
    localparam logic [3:0] ERR_UNTERMINATED   = 4'd8;

    // Character codes.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Control bytes produced by the simple escapes.
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0C;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_HT = 8'h09;

    // Surrogate ranges.
    localparam logic [15:0] HIGH_SUR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SUR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_LAST   = 16'hDFFF;

    // Most results a single input item can cause.
    localparam int MAX_RESULTS = 4;

    // Depth of the result queue and its pointer width.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queued result.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
        logic       last;
    } t_result;

    // UTF-8 form of one code point: byte count and bytes, first in slot 0.
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } t_utf8;

    // Hex digit check and value.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // UTF-8 encoding of a code point up to 21 bits.
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.bytes = '0;
        if (cp <= 21'h7F) begin
            u.count    = 3'd1;
            u.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp <= 21'h7FF) begin
            u.count    = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.count    = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.count    = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

>>> rtl/json_string_unescape_utf8.sv
// JSON string unescaper: decodes a string literal byte stream into UTF-8 result transfers.
// The first result of an input transfer passes the input register and then the result queue;
// further results of the same item follow one per cycle while the output is ready.
// Throughput: one input transfer per cycle while the result queue has room for four results;
// the output drains one result per cycle while ready; queue depth sets how long bursts are absorbed.
// Reset: synchronous, active low; the decoder waits for an opening quote and the queue is empty.
module json_string_unescape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] text_ended
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] result_kind
    output logic        o_m_axis_tlast    // last_of_run
);
    import jsu_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_ended;

    // Decoder state.
    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_high_bits, n_high_bits;

    // Result queue.
    t_result           r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Results of the item under decode.
    logic [2:0]  res_n;
    logic [1:0]  res_kind [MAX_RESULTS];
    logic [7:0]  res_byte [MAX_RESULTS];
    logic [3:0]  res_err;

    logic        decode_go;
    logic        push_ok;
    logic        pop;
    logic        in_take;
    t_hex        hex;
    logic [15:0] acc_next;
    logic [20:0] pair_cp;
    t_utf8       utf8;

    // The decoder may fire only when the queue can take a full burst of results.
    assign push_ok   = (r_count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign decode_go = r_in_valid && push_ok;
    assign o_s_axis_tready = !r_in_valid || push_ok;
    assign in_take   = i_s_axis_tvalid && o_s_axis_tready;

    // Hex accumulation and code point candidates.
    assign hex      = hex_digit(r_in_byte);
    assign acc_next = {r_acc[11:0], hex.value};
    assign pair_cp  = {11'(r_high_bits) + 11'd64, acc_next[9:0]};
    assign utf8     = utf8_encode((r_phase == PH_LOW_HEX) ? pair_cp : {5'd0, acc_next});

    // Next state and results for the item in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_hex_cnt   = r_hex_cnt;
        n_acc       = r_acc;
        n_high_bits = r_high_bits;
        res_n       = 3'd0;
        res_err     = ERR_QUOTE_EXPECTED;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res_kind[k] = KIND_BYTE;
            res_byte[k] = 8'd0;
        end
        unique case (r_phase)
            PH_WAIT: begin
                if (!r_in_ended) begin
                    if (r_in_byte == CH_QUOTE) begin
                        n_phase = PH_BODY;
                    end else begin
                        res_n       = 3'd1;
                        res_kind[0] = KIND_ERROR;
                        res_err     = ERR_QUOTE_EXPECTED;
                    end
                end
            end
            PH_BODY: begin
                res_n = 3'd1;
                if (r_in_ended) begin
                    n_phase     = PH_WAIT;
                    res_kind[0] = KIND_ERROR;
                    res_err     = ERR_UNTERMINATED;
                end else if (r_in_byte == CH_QUOTE) begin
                    n_phase     = PH_WAIT;
                    res_kind[0] = KIND_CLOSE;
                end else if (r_in_byte < CH_SPACE) begin
                    n_phase     = PH_WAIT;
                    res_kind[0] = KIND_ERROR;
                    res_err     = ERR_CONTROL_CHAR;
                end else if (r_in_byte == CH_BACKSLASH) begin
                    n_phase = PH_ESC;
                    res_n   = 3'd0;
                end else begin
                    res_byte[0] = r_in_byte;
                end
            end
            PH_ESC: begin
                res_n = 3'd1;
                if (r_in_ended) begin
                    n_phase     = PH_WAIT;
                    res_kind[0] = KIND_ERROR;
                    res_err     = ERR_BAD_ESC_END;
                end else begin
                    n_phase = PH_BODY;
                    case (r_in_byte) inside
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: res_byte[0] = r_in_byte;
                        CH_B: res_byte[0] = BYTE_BS;
                        CH_F: res_byte[0] = BYTE_FF;
                        CH_N: res_byte[0] = BYTE_LF;
                        CH_R: res_byte[0] = BYTE_CR;
                        CH_T: res_byte[0] = BYTE_HT;
                        CH_U: begin
                            n_phase   = PH_HEX;
                            n_hex_cnt = 2'd0;
                            n_acc     = 16'd0;
                            res_n     = 3'd0;
                        end
                        default: begin
                            n_phase     = PH_WAIT;
                            res_kind[0] = KIND_ERROR;
                            res_err     = ERR_INVALID_ESC;
                        end
                    endcase
                end
            end
            PH_LOW_BSL: begin
                if (r_in_ended || r_in_byte != CH_BACKSLASH) begin
                    n_phase     = PH_WAIT;
                    res_n       = 3'd1;
                    res_kind[0] = KIND_ERROR;
                    res_err     = ERR_MISSING_LOW;
                end else begin
                    n_phase = PH_LOW_U;
                end
            end
            PH_LOW_U: begin
                if (r_in_ended || r_in_byte != CH_U) begin
                    n_phase     = PH_WAIT;
                    res_n       = 3'd1;
                    res_kind[0] = KIND_ERROR;
                    res_err     = ERR_MISSING_LOW;
                end else begin
                    n_phase   = PH_LOW_HEX;
                    n_hex_cnt = 2'd0;
                    n_acc     = 16'd0;
                end
            end
            PH_HEX, PH_LOW_HEX: begin
                if (r_in_ended) begin
                    n_phase     = PH_WAIT;
                    res_n       = 3'd1;
                    res_kind[0] = KIND_ERROR;
                    res_err     = ERR_INCOMPLETE_HEX;
                end else if (!hex.ok) begin
                    n_phase     = PH_WAIT;
                    res_n       = 3'd1;
                    res_kind[0] = KIND_ERROR;
                    res_err     = ERR_BAD_HEX;
                end else begin
                    n_acc = acc_next;
                    if (r_hex_cnt != 2'd3) begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end else begin
                        n_hex_cnt = 2'd0;
                        if (r_phase == PH_HEX && acc_next >= HIGH_SUR_FIRST
                                && acc_next <= HIGH_SUR_LAST) begin
                            // High surrogate: keep its ten bits and expect the low half.
                            n_high_bits = acc_next[9:0];
                            n_phase     = PH_LOW_BSL;
                        end else if (r_phase == PH_LOW_HEX && (acc_next < LOW_SUR_FIRST
                                || acc_next > LOW_SUR_LAST)) begin
                            n_phase     = PH_WAIT;
                            res_n       = 3'd1;
                            res_kind[0] = KIND_ERROR;
                            res_err     = ERR_BAD_LOW;
                        end else begin
                            n_phase = PH_BODY;
                            res_n   = utf8.count;
                            for (int k = 0; k < MAX_RESULTS; k++) begin
                                res_byte[k] = utf8.bytes[k];
                            end
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_WAIT;
            end
        endcase
    end

    // Input register and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_WAIT;
            r_hex_cnt   <= 2'd0;
            r_acc       <= 16'd0;
            r_high_bits <= 10'd0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (decode_go) begin
                r_in_valid <= 1'b0;
            end
            if (decode_go) begin
                r_phase     <= n_phase;
                r_hex_cnt   <= n_hex_cnt;
                r_acc       <= n_acc;
                r_high_bits <= n_high_bits;
            end
        end
    end

    // Input payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_ended <= i_s_axis_tuser;
        end
    end

    // Queue write: up to four results at consecutive slots.
    always_ff @(posedge i_clk) begin
        if (decode_go) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (3'(k) < res_n) begin
                    r_queue[r_wr_ptr + QPTR_W'(k)] <= '{
                        kind: res_kind[k],
                        data: (res_kind[k] == KIND_BYTE) ? res_byte[k] : 8'd0,
                        err:  (res_kind[k] == KIND_ERROR) ? res_err : 4'd0,
                        last: (3'(k) == res_n - 3'd1)
                    };
                end
            end
        end
    end

    // Queue pointers and fill count.
    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (decode_go) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(res_n);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (decode_go ? QCNT_W'(res_n) : QCNT_W'(0))
                               - (pop ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // Master side shows the head of the queue.
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {4'd0, r_queue[r_rd_ptr].err, r_queue[r_rd_ptr].data};
    assign o_m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign o_m_axis_tlast  = r_queue[r_rd_ptr].last;

endmodule
